// ===== hw/rtl/rtt_hist_pkg.sv =====
// Shared types, sizes and request codes for the RTT sample history tracker.
// Used by rtt_sample_history_tracker_top; depends on nothing.
package rtt_hist_pkg;

  // History ring geometry
  localparam int HIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

  // Reset values
  localparam logic [15:0] MULT_RESET_CAP = 16'd64;
  localparam logic [15:0] MULT_ONE       = 16'd1;
  localparam logic [31:0] SEQ_INITIAL    = 32'd1;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_SEND   = 3'd0;
  localparam logic [2:0] REQ_ACK    = 3'd1;
  localparam logic [2:0] REQ_DOUBLE = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_RESET  = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] seq_num;
    logic [31:0] seg_size;
    logic [31:0] ack_num;
    logic [63:0] now_time;
  } req_t;

  typedef struct packed {
    logic [63:0] rtt_sample;
    logic        sample_valid;
    logic [15:0] backoff_multiplier;
    logic        history_drop;
  } rsp_t;

  // One row of the history ring
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [63:0] sent_time;
    logic        retx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Advance a ring slot, wrapping at the depth
  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    return (s == IDX_W'(HIST_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  // Slot at offset ofs from head; head + ofs stays below twice the depth
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(HIST_DEPTH)) begin
      sum = sum - (CNT_W+1)'(HIST_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/rtt_hist_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the history ring rows; no package dependency.
module rtt_hist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/rtt_sample_history_tracker_top.sv =====
// RTT sample history tracker: ring of sent segments, Karn's rule sampling, backoff.
// Depends on rtt_hist_pkg and rtt_hist_ram.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one request: send, ack,
//   double multiplier, clear history or full reset. rsp channel
//   (rsp_valid/rsp_ready/rsp_data) returns exactly one result per request.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes max_multiplier; it is
//   always ready and should be written only while the block is idle.
// Sequencing:
//   One request at a time. A new send, double, clear or reset raises rsp_valid
//   from the dispatch state; a retransmit or ack first walks n ring entries in
//   the scan state (retransmit search up to the covering entry, ack pops of fully
//   acked entries), at most HIST_DEPTH, and raises rsp_valid when the walk ends.
//   The walk reads one ring row per cycle from the history RAM. req_ready
//   returns in the cycle after the result is taken.
// Reset (rst, synchronous): ring empty, next expected sequence 1, multiplier 1,
//   max_multiplier 64. Ring rows are not cleared; only rows inside the fill
//   count are ever used.
// Stalls: a result waits in the output register while rsp_ready is low, and
//   no new request is accepted until it is taken.
module rtt_sample_history_tracker_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rtt_hist_pkg::req_t req_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rtt_hist_pkg::rsp_t rsp_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  import rtt_hist_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t             state;
  req_t               cur;
  logic [31:0]        req_end;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   fill;
  logic [31:0]        next_exp;
  logic [15:0]        mult;
  logic [15:0]        max_mult;
  logic [IDX_W-1:0]   rd_slot;
  logic [IDX_W-1:0]   cur_slot;
  logic [CNT_W-1:0]   scan_cnt;
  logic [63:0]        res_sample;
  logic               res_valid;
  logic               res_drop;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  entry_t             ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_data;

  entry_t             ent;
  logic [31:0]        ent_end;
  logic               ret_hit;
  logic               ret_ext;
  logic               ack_pop;
  logic               send_new;
  logic               hist_full;
  logic [IDX_W-1:0]   append_slot;
  logic [16:0]        mult_dbl;

  rtt_hist_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (rd_slot),
    .rd_data (ram_rd_data)
  );

  // Decode the row under inspection and the request
  assign ent         = entry_t'(ram_rd_data);
  assign ent_end     = ent.start + ent.length;
  assign ret_hit     = (cur.seq_num >= ent.start) && (cur.seq_num < ent_end);
  assign ret_ext     = req_end > next_exp;
  assign ack_pop     = ent_end <= cur.ack_num;
  assign send_new    = cur.seq_num == next_exp;
  assign hist_full   = fill == CNT_W'(HIST_DEPTH);
  assign append_slot = slot_add(head, fill);
  assign mult_dbl    = {mult, 1'b0};

  // Ring writes: append a new send, or mark a retransmitted row
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cur_slot;
    ram_wr_data = ent;
    if (state == ST_DISPATCH && cur.req_type == REQ_SEND && send_new && !hist_full) begin
      ram_wr_en             = 1'b1;
      ram_wr_addr           = append_slot;
      ram_wr_data.start     = cur.seq_num;
      ram_wr_data.length    = cur.seg_size;
      ram_wr_data.sent_time = cur.now_time;
      ram_wr_data.retx      = 1'b0;
    end else if (state == ST_SCAN && cur.req_type == REQ_SEND && ret_hit) begin
      ram_wr_en          = 1'b1;
      ram_wr_data.retx   = 1'b1;
      ram_wr_data.length = ret_ext ? (req_end - ent.start) : ent.length;
    end
  end

  // Sequencer, ring pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      fill      <= '0;
      next_exp  <= SEQ_INITIAL;
      mult      <= MULT_ONE;
      max_mult  <= MULT_RESET_CAP;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_mult <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          // Aim the read port at the head so its row is ready after dispatch
          rd_slot  <= head;
          cur_slot <= head;
          scan_cnt <= '0;
          if (req_valid) begin
            cur        <= req_data;
            req_end    <= req_data.seq_num + req_data.seg_size;
            res_sample <= '0;
            res_valid  <= 1'b0;
            res_drop   <= 1'b0;
            state      <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          rd_slot   <= slot_inc(rd_slot);
          state     <= ST_DONE;
          rsp_valid <= 1'b1;
          case (cur.req_type)
            REQ_SEND: begin
              if (send_new) begin
                if (hist_full) begin
                  res_drop <= 1'b1;
                end else begin
                  fill <= fill + 1'b1;
                end
                next_exp <= req_end;
              end else if (fill != '0) begin
                state     <= ST_SCAN;
                rsp_valid <= 1'b0;
              end
            end
            REQ_ACK: begin
              if (fill != '0) begin
                state     <= ST_SCAN;
                rsp_valid <= 1'b0;
              end
            end
            REQ_DOUBLE: begin
              mult <= (mult_dbl < {1'b0, max_mult}) ? mult_dbl[15:0] : max_mult;
            end
            REQ_CLEAR: begin
              head     <= '0;
              fill     <= '0;
              next_exp <= SEQ_INITIAL;
            end
            REQ_RESET: begin
              head     <= '0;
              fill     <= '0;
              next_exp <= SEQ_INITIAL;
              mult     <= MULT_ONE;
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          // Advance one row per cycle; the read port runs one row ahead
          rd_slot  <= slot_inc(rd_slot);
          cur_slot <= slot_inc(cur_slot);
          scan_cnt <= scan_cnt + 1'b1;
          if (cur.req_type == REQ_SEND) begin
            if (ret_hit) begin
              if (ret_ext) begin
                next_exp <= req_end;
              end
              state     <= ST_DONE;
              rsp_valid <= 1'b1;
            end else if (scan_cnt + 1'b1 == fill) begin
              state     <= ST_DONE;
              rsp_valid <= 1'b1;
            end
          end else begin
            // Take a sample only from a clean, fully acked head row
            if (scan_cnt == '0 && !ent.retx && ack_pop) begin
              res_sample <= cur.now_time - ent.sent_time;
              res_valid  <= 1'b1;
              mult       <= MULT_ONE;
            end
            if (ack_pop) begin
              head <= slot_inc(head);
              fill <= fill - 1'b1;
              if (fill == CNT_W'(1)) begin
                state     <= ST_DONE;
                rsp_valid <= 1'b1;
              end
            end else begin
              state     <= ST_DONE;
              rsp_valid <= 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign rsp_data.rtt_sample         = res_sample;
  assign rsp_data.sample_valid       = res_valid;
  assign rsp_data.backoff_multiplier = mult;
  assign rsp_data.history_drop       = res_drop;

  // A pending result blocks new requests
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request accepted while a result is pending");

  // Fill count never exceeds the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(HIST_DEPTH))
    else $error("ring fill exceeds depth");

  // The walk only runs over a non-empty ring
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> fill != '0)
    else $error("ring walk with empty history");

  // No sample means a zero sample field
  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.sample_valid |-> rsp_data.rtt_sample == '0)
    else $error("nonzero sample without sample_valid");

  // A sample and a drop never come from the same request
  a_sample_drop_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.sample_valid && rsp_data.history_drop))
    else $error("sample and drop flagged together");

endmodule
